[rtl/pitot_pkg.sv]
// shared constants for the pitot airspeed block with zero calibration
package pitot_pkg;

  localparam int unsigned GAIN_W  = 20;
  localparam int unsigned CNT_W   = 14;
  localparam int unsigned SUM_W   = 22;
  localparam int unsigned OFS_W   = 18;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned CFG_A_W = 2;

  localparam logic [CFG_A_W-1:0] REG_SPEED_GAIN = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_SEARCH_ATT = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_CAL_ATT    = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_MIN_GOOD   = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RESET       = 20'd274839;
  localparam logic [7:0]        SEARCH_ATT_RESET = 8'd20;
  localparam logic [7:0]        CAL_ATT_RESET    = 8'd50;
  localparam logic [7:0]        MIN_GOOD_RESET   = 8'd25;

  localparam logic [STAT_W-1:0] PH_SEARCH    = 3'd0;
  localparam logic [STAT_W-1:0] PH_ABSENT    = 3'd1;
  localparam logic [STAT_W-1:0] PH_CAL       = 3'd2;
  localparam logic [STAT_W-1:0] PH_CALFAIL   = 3'd3;
  localparam logic [STAT_W-1:0] PH_MEASURE   = 3'd4;
  localparam logic [STAT_W-1:0] ST_READ_FAIL = 3'd5;

  localparam logic [SPEED_W-1:0] NO_SPEED  = 16'h8000;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 16'h7FFF;

  // restoring steps of the shared subtract unit
  localparam logic [4:0] DIV_STEPS  = 5'd27;
  localparam logic [4:0] SQRT_STEPS = 5'd16;

endpackage

[rtl/pitot_airspeed_with_zero_cal.sv]
// pitot airspeed top level: read validation, zero calibration, speed via shared subtract unit
// status-only results go straight to the output register;
// a good read while measuring runs the multiply, 16 root steps, then the output register;
// a passing last calibration read with good reads runs 27 restoring divide steps, then output
// one word in work at a time, next accepted once the result enters the output register
// rst_ni clears phase, counters, offset and output valid; registers return to their reset values
module pitot_airspeed_with_zero_cal (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pitot_pkg::CFG_A_W-1:0]   cfg_addr_i,
  input  logic [pitot_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // first_byte, second_byte
  input  logic                            s_axis_tuser,   // bus_ok
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pitot_pkg::SPEED_W-1:0]   m_axis_tdata,   // speed_cms
  output logic [pitot_pkg::STAT_W-1:0]    m_axis_tuser    // phase_status
);
  import pitot_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [STAT_W-1:0]  phase_q, phase_d;
  logic [7:0]         att_q, att_d;
  logic [7:0]         good_q, good_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [OFS_W-1:0]   ofs_q, ofs_d;

  logic [GAIN_W-1:0]  gain_q;
  logic [7:0]         search_att_q;
  logic [7:0]         cal_att_q;
  logic [7:0]         min_good_q;

  logic [31:0]        src_q, src_d;
  logic [17:0]        rem_q, rem_d;
  logic [17:0]        res_q, res_d;
  logic [4:0]         step_q, step_d;
  logic [18:0]        mag_q, mag_d;
  logic               neg_q, neg_d;

  logic [STAT_W-1:0]  rstat_q, rstat_d;
  logic [SPEED_W-1:0] rspeed_q, rspeed_d;

  logic               m_valid_q;
  logic [STAT_W-1:0]  m_stat_q;
  logic [SPEED_W-1:0] m_speed_q;

  logic               in_acc;
  logic               good;
  logic [CNT_W-1:0]   count;
  logic [7:0]         att_inc;
  logic [7:0]         good_inc;
  logic [SUM_W-1:0]   sum_add;
  logic [26:0]        div_num;
  logic signed [18:0] diff_d;
  logic [38:0]        prod;
  logic [15:0]        root_sat;
  logic               out_load;

  logic [19:0]        sh_a, sh_b;
  logic [20:0]        sh_diff;
  logic               sh_ok;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign good          = s_axis_tuser && (s_axis_tdata[7:6] == 2'b00);
  assign count         = {s_axis_tdata[5:0], s_axis_tdata[15:8]};
  assign att_inc       = (att_q == 8'hFF) ? att_q : att_q + 8'd1;
  assign good_inc      = (good_q == 8'hFF) ? good_q : good_q + 8'd1;
  assign sum_add       = sum_q + SUM_W'(count);
  assign diff_d        = signed'({1'b0, count, 4'b0000}) - signed'({1'b0, ofs_q});
  assign prod          = 39'(gain_q) * 39'(mag_q);
  assign root_sat      = res_q[14] ? SPEED_MAX : {res_q[14:0], sh_ok};
  assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  // shared restoring subtract unit: divide steps and root steps
  always_comb begin
    if (state_q == S_SQRT) begin
      sh_a = {rem_q, src_q[31:30]};
      sh_b = {2'b00, res_q[15:0], 2'b01};
    end else begin
      sh_a = {1'b0, rem_q, src_q[31]};
      sh_b = {12'd0, good_q};
    end
    sh_diff = {1'b0, sh_a} - {1'b0, sh_b};
    sh_ok   = !sh_diff[20];
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    att_d    = att_q;
    good_d   = good_q;
    sum_d    = sum_q;
    ofs_d    = ofs_q;
    src_d    = src_q;
    rem_d    = rem_q;
    res_d    = res_q;
    step_d   = step_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    rstat_d  = rstat_q;
    rspeed_d = rspeed_q;
    div_num  = 27'({sum_add, 4'b0000}) + 27'(good_inc[7:1]);
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rspeed_d = NO_SPEED;
          state_d  = S_OUT;
          case (phase_q)
            PH_SEARCH: begin
              if (good) begin
                phase_d = PH_CAL;
                att_d   = 8'd0;
                good_d  = 8'd0;
                sum_d   = '0;
                rstat_d = PH_CAL;
              end else begin
                att_d   = att_inc;
                rstat_d = (att_inc >= search_att_q) ? PH_ABSENT : PH_SEARCH;
                phase_d = rstat_d;
              end
            end
            PH_CAL: begin
              att_d   = att_inc;
              rstat_d = PH_CAL;
              if (good) begin
                good_d = good_inc;
                sum_d  = sum_add;
              end else begin
                div_num = 27'({sum_q, 4'b0000}) + 27'(good_q[7:1]);
              end
              if (att_inc >= cal_att_q) begin
                if (good_d < min_good_q) begin
                  phase_d = PH_CALFAIL;
                  rstat_d = PH_CALFAIL;
                end else if (good_d == 8'd0) begin
                  ofs_d   = '0;
                  phase_d = PH_MEASURE;
                end else begin
                  src_d   = {div_num, 5'd0};
                  rem_d   = '0;
                  res_d   = '0;
                  step_d  = '0;
                  state_d = S_DIV;
                end
              end
            end
            PH_MEASURE: begin
              if (good) begin
                neg_d   = diff_d[18];
                mag_d   = diff_d[18] ? 19'(-diff_d) : 19'(diff_d);
                state_d = S_MUL;
              end else begin
                rstat_d = ST_READ_FAIL;
              end
            end
            PH_CALFAIL: begin
              rstat_d = PH_CALFAIL;
            end
            default: begin
              phase_d = PH_ABSENT;
              rstat_d = PH_ABSENT;
            end
          endcase
        end
      end
      S_MUL: begin
        src_d   = {1'b0, prod[38:8]};
        rem_d   = '0;
        res_d   = '0;
        step_d  = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        src_d  = {src_q[29:0], 2'b00};
        rem_d  = sh_ok ? sh_diff[17:0] : sh_a[17:0];
        res_d  = {res_q[16:0], sh_ok};
        step_d = step_q + 5'd1;
        if (step_q == SQRT_STEPS - 5'd1) begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        src_d  = {src_q[30:0], 1'b0};
        rem_d  = sh_ok ? sh_diff[17:0] : sh_a[17:0];
        res_d  = {res_q[16:0], sh_ok};
        step_d = step_q + 5'd1;
        if (step_q == DIV_STEPS - 5'd1) begin
          ofs_d   = {res_q[16:0], sh_ok};
          phase_d = PH_MEASURE;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // a finished root becomes the signed speed
    if (state_q == S_SQRT && step_q == SQRT_STEPS - 5'd1) begin
      rstat_d  = PH_MEASURE;
      rspeed_d = neg_q ? 16'(-root_sat) : root_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_SEARCH;
      att_q        <= '0;
      good_q       <= '0;
      sum_q        <= '0;
      ofs_q        <= '0;
      step_q       <= '0;
      gain_q       <= GAIN_RESET;
      search_att_q <= SEARCH_ATT_RESET;
      cal_att_q    <= CAL_ATT_RESET;
      min_good_q   <= MIN_GOOD_RESET;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      att_q   <= att_d;
      good_q  <= good_d;
      sum_q   <= sum_d;
      ofs_q   <= ofs_d;
      step_q  <= step_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_SPEED_GAIN: gain_q       <= cfg_wdata_i;
          REG_SEARCH_ATT: search_att_q <= cfg_wdata_i[7:0];
          REG_CAL_ATT:    cal_att_q    <= cfg_wdata_i[7:0];
          REG_MIN_GOOD:   min_good_q   <= cfg_wdata_i[7:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    rem_q    <= rem_d;
    res_q    <= res_d;
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    rstat_q  <= rstat_d;
    rspeed_q <= rspeed_d;
    if (out_load) begin
      m_stat_q  <= rstat_q;
      m_speed_q <= rspeed_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_speed_q;
  assign m_axis_tuser  = m_stat_q;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// testbench for the pitot airspeed block: drives sensor reads, predicts and checks each output word
module tb;
  import pitot_pkg::*;

  localparam int SEG_ITEMS   = 300;
  localparam int SEGMENTS    = 6;
  localparam int SETTLE_CYC  = 40;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SPEED_W-1:0] speed;
  } airspeed_word_t;

  class airspeed_scoreboard;
    logic [GAIN_W-1:0]  gain_q8;
    logic [7:0]         search_lim;
    logic [7:0]         cal_lim;
    logic [7:0]         min_good;
    logic [STAT_W-1:0]  phase;
    logic [7:0]         attempts;
    logic [7:0]         good_reads;
    logic [SUM_W-1:0]   cal_sum;
    logic [OFS_W-1:0]   zero_ofs;
    airspeed_word_t     expected_q[$];
    int                 errors;

    function new();
      gain_q8    = GAIN_RESET;
      search_lim = SEARCH_ATT_RESET;
      cal_lim    = CAL_ATT_RESET;
      min_good   = MIN_GOOD_RESET;
      phase      = PH_SEARCH;
      attempts   = '0;
      good_reads = '0;
      cal_sum    = '0;
      zero_ofs   = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_A_W-1:0] addr, logic [CFG_W-1:0] val);
      case (addr)
        REG_SPEED_GAIN: gain_q8 = val;
        REG_SEARCH_ATT: search_lim = val[7:0];
        REG_CAL_ATT:    cal_lim = val[7:0];
        REG_MIN_GOOD:   min_good = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] floor_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= v) r = t;
      end
      return r[31:0];
    endfunction

    function void note_read(logic ok, logic [7:0] b0, logic [7:0] b1);
      logic               good;
      logic [CNT_W-1:0]   cnt;
      airspeed_word_t     w;
      int                 d;
      logic [31:0]        mag;
      logic [31:0]        num;
      logic [63:0]        prod;
      logic [31:0]        r;
      good = ok && (b0[7:6] == 2'b00);
      cnt = {b0[5:0], b1};
      w.speed = NO_SPEED;
      w.status = phase;
      case (phase)
        PH_SEARCH: begin
          if (good) begin
            phase = PH_CAL;
            attempts = '0;
            good_reads = '0;
            cal_sum = '0;
          end else begin
            if (attempts != 8'hFF) attempts++;
            if (attempts >= search_lim) phase = PH_ABSENT;
          end
          w.status = phase;
        end
        PH_CAL: begin
          if (attempts != 8'hFF) attempts++;
          if (good) begin
            if (good_reads != 8'hFF) good_reads++;
            cal_sum = cal_sum + cnt;
          end
          w.status = PH_CAL;
          if (attempts >= cal_lim) begin
            if (good_reads < min_good) begin
              phase = PH_CALFAIL;
              w.status = PH_CALFAIL;
            end else begin
              if (good_reads == 0) begin
                zero_ofs = '0;
              end else begin
                num = {6'd0, cal_sum, 4'd0} + 32'(good_reads >> 1);
                zero_ofs = OFS_W'(num / 32'(good_reads));
              end
              phase = PH_MEASURE;
            end
          end
        end
        PH_MEASURE: begin
          if (good) begin
            d = int'(cnt) * 16 - int'(zero_ofs);
            mag = (d < 0) ? 32'(-d) : 32'(d);
            prod = (64'(gain_q8) * 64'(mag)) >> 8;
            r = floor_root(prod);
            if (r > 32'(SPEED_MAX)) r = 32'(SPEED_MAX);
            w.speed = (d < 0) ? SPEED_W'(32'd0 - r) : SPEED_W'(r);
            w.status = PH_MEASURE;
          end else begin
            w.status = ST_READ_FAIL;
          end
        end
        PH_CALFAIL: w.status = PH_CALFAIL;
        default: begin
          phase = PH_ABSENT;
          w.status = PH_ABSENT;
        end
      endcase
      expected_q.push_back(w);
    endfunction

    function void check_word(logic [STAT_W-1:0] st, logic [SPEED_W-1:0] sp);
      airspeed_word_t w;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: status %0d speed %0d", st, $signed(sp));
        return;
      end
      w = expected_q.pop_front();
      if (st !== w.status || sp !== w.speed) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: status exp %0d got %0d, speed exp %0d got %0d",
                   w.status, st, $signed(w.speed), $signed(sp));
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CFG_A_W-1:0]  cfg_addr_i = '0;
  logic [CFG_W-1:0]    cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SPEED_W-1:0]  m_axis_tdata;
  logic [STAT_W-1:0]   m_axis_tuser;

  int                  src_idle_pct = 18;
  int                  dst_idle_pct = 52;
  int                  cycles = 0;
  airspeed_scoreboard  sb;

  pitot_airspeed_with_zero_cal uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_read(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_word(m_axis_tuser, m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(addr, val);
    @(posedge clk_i);
  endtask

  task automatic send_read(input logic ok, input logic [1:0] st, input logic [CNT_W-1:0] cnt);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {cnt[7:0], st, cnt[13:8]};
    s_axis_tuser <= ok;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random_read();
    int               kind;
    int               near_cnt;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       st;
    logic             ok;
    kind = $urandom_range(99);
    if (kind < 40) begin
      // counts close to the zero offset, both signs
      near_cnt = int'(sb.zero_ofs >> 4) - 64 + int'($urandom_range(128));
      if (near_cnt < 0) near_cnt = 0;
      if (near_cnt > 16383) near_cnt = 16383;
      cnt = CNT_W'(near_cnt);
    end else if (kind < 85) begin
      cnt = CNT_W'($urandom);
    end else begin
      cnt = $urandom_range(1) ? 14'h3FFF : 14'h0000;
    end
    ok = ($urandom_range(99) < 93);
    st = ($urandom_range(99) < 90) ? 2'b00 : 2'($urandom_range(3, 1));
    send_read(ok, st, cnt);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  initial begin
    logic [CNT_W-1:0] base;
    logic [GAIN_W-1:0] gain;
    sb = new();
    base = CNT_W'($urandom_range(12000, 2000));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_SPEED_GAIN, 20'hFFFFF);
    write_reg(REG_SEARCH_ATT, 20'd255);
    write_reg(REG_CAL_ATT, 20'd8);
    write_reg(REG_MIN_GOOD, 20'd3);

    // searching: failed transfer, each nonzero status, then a good read
    send_read(1'b0, 2'b00, 14'h0000);
    send_read(1'b1, 2'b01, 14'h00FF);
    send_read(1'b1, 2'b10, 14'h0000);
    send_read(1'b1, 2'b11, 14'h3FFF);
    send_read(1'b1, 2'b00, 14'h3FFF);

    // calibration: six good reads averaging to base + 1, two bad ones
    send_read(1'b1, 2'b00, base);
    send_read(1'b0, 2'b00, base + 14'd7);
    send_read(1'b1, 2'b00, base + 14'd2);
    send_read(1'b1, 2'b01, base);
    send_read(1'b1, 2'b00, base);
    send_read(1'b1, 2'b00, base + 14'd1);
    send_read(1'b1, 2'b00, base + 14'd1);
    send_read(1'b1, 2'b00, base + 14'd2);

    // measuring: count extremes, zero and negative difference, bad reads
    send_read(1'b1, 2'b00, 14'h0000);
    send_read(1'b1, 2'b00, 14'h3FFF);
    send_read(1'b1, 2'b00, base + 14'd1);
    send_read(1'b1, 2'b00, base);
    send_read(1'b0, 2'b00, base + 14'd5);
    send_read(1'b1, 2'b11, base);
    settle();

    write_reg(REG_SPEED_GAIN, 20'd0);
    send_read(1'b1, 2'b00, 14'h3FFF);
    send_read(1'b1, 2'b00, 14'h0000);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg)
        0: gain = GAIN_W'($urandom_range(1048575));
        1: gain = 20'hFFFFF;
        2: gain = 20'd1;
        3: gain = GAIN_RESET;
        4: gain = GAIN_W'($urandom_range(4095));
        default: gain = GAIN_W'($urandom_range(1048575));
      endcase
      write_reg(REG_SPEED_GAIN, gain);
      write_reg(REG_SEARCH_ATT, (seg % 2 == 0) ? 20'd1 : 20'd255);
      write_reg(REG_CAL_ATT, (seg % 2 == 0) ? 20'd255 : 20'd1);
      write_reg(REG_MIN_GOOD, (seg % 2 == 0) ? 20'd1 : 20'd255);
      src_idle_pct = (seg < 2) ? 18 : (seg < 4) ? 52 : 0;
      dst_idle_pct = (seg < 2) ? 52 : (seg < 4) ? 18 : 0;
      repeat (SEG_ITEMS) send_random_read();
    end

    settle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
